[rtl/core/dtc_pkg.sv]
`default_nettype none
package dtc_pkg;

   localparam int CODE_W     = 6;
   localparam int VREF_W     = 4;
   localparam int STEPS_W    = 8;
   localparam int TIDX_W     = 3;
   localparam int TEMP_W     = 16;
   localparam int RATE_MAX_W = 4;   // enough for up to 16 rates
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;
   localparam int NUM_THRESH = 7;

   localparam logic [CODE_W-1:0]  CODE_MAX    = 6'd43;
   localparam logic [CODE_W-1:0]  CODE_MIN    = 6'd0;
   localparam logic [CODE_W-1:0]  CODE_BASE   = 6'd13;
   localparam logic [STEPS_W-1:0] TABLE_LOOPS = 8'd128;

   localparam logic action_start  = 1'b0;
   localparam logic action_sample = 1'b1;

   localparam logic signed [TEMP_W-1:0] TEMP_THRESH [NUM_THRESH] = '{
      -16'sd376, -16'sd309, -16'sd241, -16'sd174, -16'sd106, -16'sd44, 16'sd29
   };

   localparam logic [STEPS_W-1:0] LOOP_LEN [4] = '{8'd16, 8'd24, 8'd32, 8'd48};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FINAL_STEP_SELECT     = 3'd0,
      CSR_TRACKING_ON           = 3'd1,
      CSR_FREQ_SELECT           = 3'd2,
      CSR_LOAD_STORED           = 3'd3,
      CSR_EXTERNAL_CAL          = 3'd4,
      CSR_CONTINUOUS_ENABLE     = 3'd5,
      CSR_INITIAL_CAL_COMPLETE  = 3'd6,
      CSR_LOAD_CONTINUOUS_ENTRY = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_FIRST = 4'b0010,
      PH_NEXT  = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] final_step_select;
      logic       tracking_on;
      logic [2:0] freq_select;
      logic       load_stored;
      logic       external_cal;
      logic       continuous_enable;
      logic       initial_cal_complete;
      logic       load_continuous_entry;
   } cfg_type;

   // classified beat, as held in the queue
   typedef struct packed {
      logic                  action;
      logic                  step_mode;
      logic [RATE_MAX_W-1:0] rate;
      logic [TIDX_W-1:0]     tidx;
      logic                  compare_out;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/core/dtc_req_if.sv]
`default_nettype none
interface dtc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic        step_mode;
   logic [2:0]  rate_index;
   logic signed [15:0] temperature;
   logic        compare_out;

   modport source (output valid, action, step_mode, rate_index, temperature, compare_out,
                   input ready);
   modport sink   (input valid, action, step_mode, rate_index, temperature, compare_out,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/dtc_rsp_if.sv]
`default_nettype none
interface dtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] trim_code;
   logic [3:0] vref_select;
   logic       done_res;
   logic       pass_flag;
   logic       need_sample;

   modport source (output valid, trim_code, vref_select, done_res, pass_flag, need_sample,
                   input ready);
   modport sink   (input valid, trim_code, vref_select, done_res, pass_flag, need_sample,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/dll_supply_trim_calibration_unit.sv]
`default_nettype none
// An accepted request beat is written into the queue, then executed into the
// response register when the back end pops it.
// Throughput: one beat per cycle while the response channel accepts results,
// set by the execute stage.
// Reset (synchronous, active high): control state, configuration and all saved
// trim codes clear at once; no clearing pass.
module dll_supply_trim_calibration_unit #(
   parameter int NUM_RATES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   dtc_req_if.sink                            req_chan,
   dtc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_en,
   input  logic [dtc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dtc_pkg::CSR_DATA_W-1:0]     csr_data
);

   dtc_pkg::cfg_type cfg_ff, cfg_in;
   logic             push_valid, push_ready;
   dtc_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   dtc_pkg::cmd_type pop_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (dtc_pkg::csr_index_type'(csr_index))
            dtc_pkg::CSR_FINAL_STEP_SELECT:     cfg_in.final_step_select     = csr_data[1:0];
            dtc_pkg::CSR_TRACKING_ON:           cfg_in.tracking_on           = csr_data[0];
            dtc_pkg::CSR_FREQ_SELECT:           cfg_in.freq_select           = csr_data[2:0];
            dtc_pkg::CSR_LOAD_STORED:           cfg_in.load_stored           = csr_data[0];
            dtc_pkg::CSR_EXTERNAL_CAL:          cfg_in.external_cal          = csr_data[0];
            dtc_pkg::CSR_CONTINUOUS_ENABLE:     cfg_in.continuous_enable     = csr_data[0];
            dtc_pkg::CSR_INITIAL_CAL_COMPLETE:  cfg_in.initial_cal_complete  = csr_data[0];
            dtc_pkg::CSR_LOAD_CONTINUOUS_ENTRY: cfg_in.load_continuous_entry = csr_data[0];
            default:                            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtc_front #(
      .NUM_RATES (NUM_RATES)
   ) u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   dtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   dtc_back #(
      .NUM_RATES (NUM_RATES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

[rtl/core/dtc_front.sv]
`default_nettype none
module dtc_front #(
   parameter int NUM_RATES = 8
) (
   dtc_req_if.sink            req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output dtc_pkg::cmd_type   push_cmd
);

   localparam int RATE_W = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;

   logic [RATE_W-1:0]         rate_sat;
   logic [dtc_pkg::TIDX_W-1:0] tidx;

   // out-of-range rates fold onto the top entry
   always_comb begin
      if (32'(req_chan.rate_index) >= 32'(NUM_RATES)) begin
         rate_sat = RATE_W'(NUM_RATES - 1);
      end else begin
         rate_sat = RATE_W'(req_chan.rate_index);
      end
   end

   // temperature bin: count of thresholds at or below the reading
   always_comb begin
      tidx = '0;
      for (int i = 0; i < dtc_pkg::NUM_THRESH; i++) begin
         tidx = tidx + dtc_pkg::TIDX_W'(req_chan.temperature >= dtc_pkg::TEMP_THRESH[i]);
      end
   end

   always_comb begin
      push_cmd.action      = req_chan.action;
      push_cmd.step_mode   = req_chan.step_mode;
      push_cmd.rate        = dtc_pkg::RATE_MAX_W'(rate_sat);
      push_cmd.tidx        = tidx;
      push_cmd.compare_out = req_chan.compare_out;
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule
`default_nettype wire

[rtl/core/dtc_queue.sv]
`default_nettype none
module dtc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dtc_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dtc_pkg::cmd_type pop_cmd
);

   dtc_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[rtl/core/dtc_back.sv]
`default_nettype none
module dtc_back #(
   parameter int NUM_RATES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  dtc_pkg::cfg_type cfg,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  dtc_pkg::cmd_type pop_cmd,
   dtc_rsp_if.source        rsp_chan
);

   localparam int RATE_W = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
   localparam int SLOT_W = $clog2(2 * NUM_RATES);
   localparam int SLOTS  = 2 * NUM_RATES;

   function automatic logic [SLOT_W-1:0] slot(input logic bank, input logic [RATE_W-1:0] r);
      logic [SLOT_W-1:0] base;
      base = SLOT_W'(r);
      return bank ? (SLOT_W'(NUM_RATES) + base) : base;
   endfunction

   logic [dtc_pkg::CODE_W-1:0]  saved_ff [SLOTS];
   logic [dtc_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [dtc_pkg::VREF_W-1:0]  vref_ff, vref_in;
   logic                        first_dir_ff, first_dir_in;
   logic [dtc_pkg::STEPS_W-1:0] steps_ff, steps_in;
   dtc_pkg::phase_type          phase_ff, phase_in;
   logic                        run_mode_ff, run_mode_in;
   logic [RATE_W-1:0]           run_rate_ff, run_rate_in;
   logic                        pass_ff, pass_in;

   logic                        out_valid_ff, out_valid_in;
   logic [dtc_pkg::CODE_W-1:0]  out_code_ff;
   logic [dtc_pkg::VREF_W-1:0]  out_vref_ff;
   logic                        out_done_ff, out_pass_ff, out_need_ff;

   logic                        pop;
   logic [RATE_W-1:0]           cmd_rate;
   logic                        rd_bank;
   logic [dtc_pkg::CODE_W-1:0]  rd_code;
   logic                        do_step, do_finish, go;
   logic                        down;
   logic [dtc_pkg::CODE_W-1:0]  step_code;
   logic [dtc_pkg::VREF_W-1:0]  ofs;
   logic                        wr_pu, wr_cont;
   logic [SLOT_W-1:0]           slot_pu, slot_cont;

   assign pop       = pop_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign cmd_rate  = pop_cmd.rate[RATE_W-1:0];

   // one store read per beat: the bank follows the bypass rules
   always_comb begin
      if (cfg.initial_cal_complete) begin
         rd_bank = cfg.load_stored ? cfg.load_continuous_entry : 1'b1;
      end else begin
         rd_bank = !cfg.external_cal;
      end
      rd_code = saved_ff[slot(rd_bank, cmd_rate)];
   end

   always_comb begin
      unique case (cfg.freq_select)
         3'd7:    ofs = 4'd2;
         3'd5:    ofs = 4'd5;
         3'd4:    ofs = 4'd6;
         default: ofs = 4'd3;
      endcase
   end

   always_comb begin
      down = run_mode_ff ? !pop_cmd.compare_out : pop_cmd.compare_out;
      if (down) begin
         step_code = (code_ff != dtc_pkg::CODE_MIN) ? code_ff - 6'd1 : code_ff;
      end else begin
         step_code = (code_ff != dtc_pkg::CODE_MAX) ? code_ff + 6'd1 : code_ff;
      end
   end

   always_comb begin
      code_in      = code_ff;
      vref_in      = vref_ff;
      first_dir_in = first_dir_ff;
      steps_in     = steps_ff;
      phase_in     = phase_ff;
      run_mode_in  = run_mode_ff;
      run_rate_in  = run_rate_ff;
      pass_in      = pass_ff;
      do_step      = 1'b0;
      do_finish    = 1'b0;
      go           = 1'b0;

      if (pop) begin
         if (pop_cmd.action == dtc_pkg::action_start) begin
            if (cfg.initial_cal_complete) begin
               if (cfg.load_stored) begin
                  code_in  = rd_code;
                  phase_in = dtc_pkg::PH_DONE;
               end else if (!cfg.continuous_enable) begin
                  phase_in = dtc_pkg::PH_DONE;
               end else begin
                  go = 1'b1;
               end
            end else if (cfg.external_cal) begin
               code_in  = rd_code;
               phase_in = dtc_pkg::PH_DONE;
            end else begin
               go = 1'b1;
            end

            if (go) begin
               pass_in     = 1'b1;
               run_mode_in = pop_cmd.step_mode;
               run_rate_in = cmd_rate;
               phase_in    = dtc_pkg::PH_FIRST;
               if (!cfg.tracking_on && !pop_cmd.step_mode) begin
                  vref_in  = dtc_pkg::VREF_W'(pop_cmd.tidx) + ofs;
                  code_in  = dtc_pkg::CODE_W'(pop_cmd.tidx) + dtc_pkg::CODE_BASE;
                  steps_in = dtc_pkg::TABLE_LOOPS;
               end else begin
                  code_in  = rd_code;
                  steps_in = dtc_pkg::LOOP_LEN[cfg.final_step_select];
               end
            end
         end else begin
            unique case (phase_ff)
               dtc_pkg::PH_FIRST: begin
                  first_dir_in = pop_cmd.compare_out;
                  do_step      = 1'b1;
               end
               dtc_pkg::PH_NEXT: begin
                  if (!run_mode_ff && (pop_cmd.compare_out != first_dir_ff)) begin
                     do_finish = 1'b1;
                  end else if (steps_ff == '0) begin
                     do_finish = 1'b1;
                  end else begin
                     steps_in = steps_ff - 8'd1;
                     do_step  = 1'b1;
                  end
               end
               default: begin
                  // sample while idle or finished: no change
               end
            endcase

            if (do_step) begin
               code_in = step_code;
               if ((step_code == dtc_pkg::CODE_MIN) || (step_code == dtc_pkg::CODE_MAX)) begin
                  pass_in   = 1'b0;
                  do_finish = 1'b1;
               end else if (cfg.tracking_on) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = dtc_pkg::PH_NEXT;
               end
            end

            if (do_finish) begin
               phase_in = dtc_pkg::PH_DONE;
            end
         end
      end
   end

   assign wr_pu     = do_finish && !cfg.tracking_on;
   assign wr_cont   = do_finish;
   assign slot_pu   = slot(1'b0, run_rate_ff);
   assign slot_cont = slot(1'b1, run_rate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            saved_ff[i] <= '0;
         end
      end else begin
         if (wr_pu) begin
            saved_ff[slot_pu] <= code_in;
         end
         if (wr_cont) begin
            saved_ff[slot_cont] <= code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= '0;
         vref_ff      <= '0;
         first_dir_ff <= 1'b0;
         steps_ff     <= '0;
         phase_ff     <= dtc_pkg::PH_IDLE;
         run_mode_ff  <= 1'b0;
         run_rate_ff  <= '0;
         pass_ff      <= 1'b0;
      end else begin
         code_ff      <= code_in;
         vref_ff      <= vref_in;
         first_dir_ff <= first_dir_in;
         steps_ff     <= steps_in;
         phase_ff     <= phase_in;
         run_mode_ff  <= run_mode_in;
         run_rate_ff  <= run_rate_in;
         pass_ff      <= pass_in;
      end
   end

   // result register: each popped beat yields one result beat
   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_code_ff <= code_in;
         out_vref_ff <= vref_in;
         out_done_ff <= (phase_in == dtc_pkg::PH_DONE);
         out_pass_ff <= pass_in;
         out_need_ff <= (phase_in == dtc_pkg::PH_FIRST) || (phase_in == dtc_pkg::PH_NEXT);
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.trim_code   = out_code_ff;
   assign rsp_chan.vref_select = out_vref_ff;
   assign rsp_chan.done_res    = out_done_ff;
   assign rsp_chan.pass_flag   = out_pass_ff;
   assign rsp_chan.need_sample = out_need_ff;

endmodule
`default_nettype wire
